/* hdl/http_host_header_blocker_unit_assert.svh */
// Assertion macros for the Host header blocker.
`ifndef HTTP_HOST_HEADER_BLOCKER_UNIT_ASSERT_SVH
`define HTTP_HOST_HEADER_BLOCKER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define HHB_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("hhb assertion failed");
// Next-cycle implication.
`define HHB_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("hhb assertion failed");
`else
`define HHB_ASSERT_NOW(lbl, ant, cons)
`define HHB_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

/* hdl/hhb_pkg.sv */
// Shared constants and helpers for the Host header blocker.
package hhb_pkg;

  // Longest capture that is compared; longer ones saturate as a mismatch.
  localparam logic [5:0] MAX_SITE        = 6'd32;
  // Number of site bytes held in the configuration registers.
  localparam logic [5:0] SITE_BYTES_HELD = 6'd32;

  // Character codes
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Register indexes (address bits [5:3])
  localparam logic [2:0] REG_SITE_A   = 3'd0;
  localparam logic [2:0] REG_SITE_B   = 3'd1;
  localparam logic [2:0] REG_SITE_C   = 3'd2;
  localparam logic [2:0] REG_SITE_D   = 3'd3;
  localparam logic [2:0] REG_SITE_LEN = 3'd4;

  // Expected keyword character for keyword progress 0..4 ("Host:")
  function automatic logic [7:0] keyword_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = CH_H;
      3'd1: c = CH_O;
      3'd2: c = CH_S;
      3'd3: c = CH_T;
      3'd4: c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/http_host_header_blocker_unit.sv */
// Host header blocker: one payload byte per cycle, verdict on the last byte.
// A verdict is registered in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; bytes stall only while a verdict is held
//   and the verdict side is not ready.
// Reset: rst (synchronous) clears the scan state, the verdict valid and the
//   site registers; the block is ready for bytes as soon as reset is released.
module http_host_header_blocker_unit
  import hhb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  input  logic [31:0] queue_id,
  // verdicts
  output logic        verdict_valid,
  input  logic        verdict_ready,
  output logic        verdict_drop,
  output logic [31:0] verdict_id,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_H, PH_HO, PH_HOS, PH_HOST, PH_COLON, PH_CAPTURE
  } phase_t;

  // Configuration registers
  logic [63:0] site_bytes_a, site_bytes_b, site_bytes_c, site_bytes_d;
  logic [5:0]  site_length;

  // Scan state
  phase_t     phase, phase_next;
  logic [5:0] capture_count, capture_count_next;
  logic       capture_differs, capture_differs_next;
  logic       leading_space, leading_space_next;
  logic       cr_seen, cr_seen_next;
  logic       match_decided, match_decided_next;
  logic       block_flag, block_flag_next;

  logic        accept;
  logic        cfg_write;
  logic [63:0] site_word;
  logic [7:0]  site_byte;
  logic [7:0]  cap_in;
  logic [5:0]  cap_count;
  logic        cap_differs;
  logic [2:0]  scan_phase;

  // Config port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_bytes_a <= '0;
      site_bytes_b <= '0;
      site_bytes_c <= '0;
      site_bytes_d <= '0;
      site_length  <= '0;
    end else if (cfg_write) begin
      case (paddr[5:3])
        REG_SITE_A:   site_bytes_a <= pwdata;
        REG_SITE_B:   site_bytes_b <= pwdata;
        REG_SITE_C:   site_bytes_c <= pwdata;
        REG_SITE_D:   site_bytes_d <= pwdata;
        REG_SITE_LEN: site_length  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_SITE_A:   prdata = site_bytes_a;
      REG_SITE_B:   prdata = site_bytes_b;
      REG_SITE_C:   prdata = site_bytes_c;
      REG_SITE_D:   prdata = site_bytes_d;
      REG_SITE_LEN: prdata = {58'd0, site_length};
      default:      prdata = '0;
    endcase
  end

  // Handshake: a byte is taken unless a verdict is stuck in the output
  assign byte_ready = ~verdict_valid | verdict_ready;
  assign accept     = byte_valid & byte_ready;

  // Site byte at the current capture position
  always_comb begin
    case (capture_count[4:3])
      2'd0:    site_word = site_bytes_a;
      2'd1:    site_word = site_bytes_b;
      2'd2:    site_word = site_bytes_c;
      default: site_word = site_bytes_d;
    endcase
    site_byte = site_word[{capture_count[2:0], 3'b000} +: 8];
  end

  // Capture step; a space followed directly by CR is captured as the value
  always_comb begin
    cap_in = (payload_byte == CH_CR) ? CH_SPACE : payload_byte;
    if (capture_count >= MAX_SITE) begin
      cap_count   = capture_count;
      cap_differs = 1'b1;
    end else begin
      cap_count   = capture_count + 6'd1;
      cap_differs = capture_differs | (capture_count >= SITE_BYTES_HELD) |
                    (capture_count >= site_length) | (site_byte != cap_in);
    end
  end

  // Keyword match step, restart on H
  always_comb begin
    if ((phase < PH_COLON) && (payload_byte == keyword_char(phase)))
      scan_phase = phase + 3'd1;
    else if (payload_byte == CH_H)
      scan_phase = PH_H;
    else
      scan_phase = PH_IDLE;
  end

  // Next scan state for one byte
  always_comb begin
    phase_next           = phase;
    capture_count_next   = capture_count;
    capture_differs_next = capture_differs;
    leading_space_next   = leading_space;
    cr_seen_next         = cr_seen;
    match_decided_next   = match_decided;
    block_flag_next      = block_flag;
    if (!match_decided) begin
      if (phase < PH_COLON) begin
        phase_next = phase_t'(scan_phase);
        if (scan_phase == PH_COLON) begin
          capture_count_next   = '0;
          capture_differs_next = 1'b0;
          leading_space_next   = 1'b0;
          cr_seen_next         = 1'b0;
        end
      end else if (phase == PH_COLON) begin
        if (payload_byte == CH_SPACE) begin
          leading_space_next = 1'b1;
          phase_next         = PH_CAPTURE;
        end else if (payload_byte == CH_CR || payload_byte == CH_LF) begin
          phase_next = PH_IDLE;
        end else begin
          capture_count_next   = cap_count;
          capture_differs_next = cap_differs;
          phase_next           = PH_CAPTURE;
        end
      end else if (cr_seen) begin
        if (payload_byte == CH_LF) begin
          match_decided_next = 1'b1;
          block_flag_next    = ~capture_differs & (capture_count == site_length);
        end else begin
          // failed terminator: rescan from this byte
          cr_seen_next = 1'b0;
          phase_next   = (payload_byte == CH_H) ? PH_H : PH_IDLE;
        end
      end else if (payload_byte == CH_CR) begin
        if (capture_count == 6'd0) begin
          if (leading_space) begin
            capture_count_next   = cap_count;
            capture_differs_next = cap_differs;
            cr_seen_next         = 1'b1;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          cr_seen_next = 1'b1;
        end
      end else if (payload_byte == CH_LF) begin
        phase_next = PH_IDLE;
      end else begin
        capture_count_next   = cap_count;
        capture_differs_next = cap_differs;
      end
    end
  end

  // State and verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      capture_count   <= '0;
      capture_differs <= 1'b0;
      leading_space   <= 1'b0;
      cr_seen         <= 1'b0;
      match_decided   <= 1'b0;
      block_flag      <= 1'b0;
      verdict_valid   <= 1'b0;
    end else begin
      if (accept && last_byte) begin
        phase           <= PH_IDLE;
        capture_count   <= '0;
        capture_differs <= 1'b0;
        leading_space   <= 1'b0;
        cr_seen         <= 1'b0;
        match_decided   <= 1'b0;
        block_flag      <= 1'b0;
        verdict_valid   <= 1'b1;
        verdict_drop    <= match_decided_next & block_flag_next;
        verdict_id      <= queue_id;
      end else begin
        if (accept) begin
          phase           <= phase_next;
          capture_count   <= capture_count_next;
          capture_differs <= capture_differs_next;
          leading_space   <= leading_space_next;
          cr_seen         <= cr_seen_next;
          match_decided   <= match_decided_next;
          block_flag      <= block_flag_next;
        end
        if (verdict_ready)
          verdict_valid <= 1'b0;
      end
    end
  end

`include "http_host_header_blocker_unit_assert.svh"

  `HHB_ASSERT_NOW(a_count_bound, 1'b1, capture_count <= MAX_SITE)
  `HHB_ASSERT_NOW(a_cr_in_capture, cr_seen, phase == PH_CAPTURE)
  `HHB_ASSERT_NEXT(a_last_clears, accept && last_byte, verdict_valid && !match_decided)
  `HHB_ASSERT_NEXT(a_id_echo, accept && last_byte, verdict_id == $past(queue_id))

endmodule
